@@ hw/rtl/llm_pkg.sv @@
// Shared types, constants and arithmetic helpers of the link liveness monitor.
`default_nettype none

package llm_pkg;

  typedef enum logic [1:0] {
    HEALTH_UNKNOWN = 2'd0,
    HEALTH_HEALTHY = 2'd1,
    HEALTH_SUSPECT = 2'd2,
    HEALTH_OFFLINE = 2'd3
  } health_e;

  typedef enum logic [2:0] {
    CMD_RESTART    = 3'd0,
    CMD_SUCCESS    = 3'd1,
    CMD_MISS       = 3'd2,
    CMD_TICK       = 3'd3,
    CMD_PROBE_SENT = 3'd4
  } cmd_e;

  localparam logic [31:0] SRTT_RESET       = 32'd100000;
  localparam logic [31:0] RTTVAR_RESET     = 32'd50000;
  localparam logic [16:0] LOSS_LOW_MARK    = 17'd1311;
  localparam logic [19:0] LOSS_MISS_STEP   = 20'd65536;
  localparam logic [33:0] RTO_VAR_FLOOR    = 34'd10000;
  localparam logic [19:0] ROUND_UP_1000    = 20'd999;
  // ceil(2^30 / 1000): exact floor division for dividends below 2^20
  localparam logic [20:0] RECIP_1000       = 21'd1073742;
  localparam int unsigned RECIP_SHIFT      = 30;
  // 1000000 / 65536 == 15625 / 1024
  localparam logic [13:0] PPM_NUM          = 14'd15625;
  localparam logic [9:0]  SUSPECT_INTERVAL = 10'd100;
  localparam logic [7:0]  MISS_MAX         = 8'd255;

  typedef struct packed {
    logic [9:0]  interval;     // interval when not suspect
    logic [9:0]  rto;
    logic [10:0] off_b3;       // offline deadline, budget 3, not suspect
    logic [10:0] off_b4;
    logic [10:0] off_b3_susp;  // same with the suspect interval
    logic [10:0] off_b4_susp;
  } timers_t;

  typedef struct packed {
    health_e     health;
    logic [31:0] srtt;
    logic [31:0] rttvar;
    logic [16:0] loss;
    logic [7:0]  miss;
    logic        seeded;
    logic [47:0] last_ack;
    logic [47:0] next_probe;
  } state_t;

  // ceil(v / 1000) for v up to 1000000
  function automatic logic [9:0] ceil_div1000(input logic [19:0] v);
    logic [19:0] w;
    logic [40:0] prod;
    begin
      w    = v + ROUND_UP_1000;
      prod = {21'b0, w} * {20'b0, RECIP_1000};
      return prod[RECIP_SHIFT+9:RECIP_SHIFT];
    end
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] base, input logic [9:0] ival);
    logic [48:0] t;
    begin
      t = {1'b0, base} + {39'b0, ival};
      return t[48] ? {48{1'b1}} : t[47:0];
    end
  endfunction

  function automatic logic [9:0] cur_interval(input health_e h, input timers_t tm);
    return (h == HEALTH_SUSPECT) ? SUSPECT_INTERVAL : tm.interval;
  endfunction

  function automatic logic low_loss(input logic [16:0] loss);
    return loss < LOSS_LOW_MARK;
  endfunction

  function automatic logic [10:0] cur_offline(input health_e h, input logic [16:0] loss,
                                              input timers_t tm);
    logic susp;
    logic low;
    begin
      susp = (h == HEALTH_SUSPECT);
      low  = low_loss(loss);
      if (susp) begin
        return low ? tm.off_b3_susp : tm.off_b4_susp;
      end
      return low ? tm.off_b3 : tm.off_b4;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/llm_timers.sv @@
// Two-stage timer estimate pipeline: probe interval, RTO and offline deadlines.
`default_nettype none

module llm_timers (
  input  wire logic                  clk_i,
  input  wire logic                  profile_i,
  input  wire logic [31:0]           srtt_i,
  input  wire logic [31:0]           rttvar_i,
  output llm_pkg::timers_t           timers_o
);

  logic [9:0]  interval_q, interval_d;
  logic [9:0]  rto_q, rto_d;
  logic [10:0] off_b3_q, off_b4_q, off_b3_susp_q, off_b4_susp_q;

  logic [33:0] est;
  logic [34:0] iv, iv_lo, iv_hi, iv_c;
  logic [33:0] var4, var_term;
  logic [34:0] rv, rv_hi, rv_c;

  function automatic logic [10:0] offline_calc(input logic [9:0] rto, input logic [11:0] bi,
                                               input logic profile);
    logic [11:0] d;
    logic [11:0] lo;
    logic [11:0] hi;
    begin
      d  = ({2'b0, rto} > bi) ? {2'b0, rto} : bi;
      lo = profile ? 12'd900 : 12'd600;
      hi = profile ? 12'd1800 : 12'd900;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      return d[10:0];
    end
  endfunction

  // Stage one: clamp the dividend, then round up to milliseconds
  always_comb begin
    est   = {2'b0, srtt_i} + {1'b0, rttvar_i, 1'b0};
    iv    = profile_i ? {est, 1'b0} : {1'b0, est};
    iv_lo = profile_i ? 35'd250000 : 35'd100000;
    iv_hi = profile_i ? 35'd750000 : 35'd250000;
    if (iv < iv_lo) begin
      iv_c = iv_lo;
    end else if (iv > iv_hi) begin
      iv_c = iv_hi;
    end else begin
      iv_c = iv;
    end
    interval_d = llm_pkg::ceil_div1000(iv_c[19:0]);

    var4     = {rttvar_i, 2'b0};
    var_term = (var4 > llm_pkg::RTO_VAR_FLOOR) ? var4 : llm_pkg::RTO_VAR_FLOOR;
    rv       = {3'b0, srtt_i} + {1'b0, var_term};
    rv_hi    = profile_i ? 35'd1000000 : 35'd500000;
    if (rv < 35'd100000) begin
      rv_c = 35'd100000;
    end else if (rv > rv_hi) begin
      rv_c = rv_hi;
    end else begin
      rv_c = rv;
    end
    rto_d = llm_pkg::ceil_div1000(rv_c[19:0]);
  end

  always_ff @(posedge clk_i) begin
    interval_q <= interval_d;
    rto_q      <= rto_d;
  end

  // Stage two: offline deadline for each budget and interval choice
  always_ff @(posedge clk_i) begin
    off_b3_q      <= offline_calc(rto_q, {1'b0, interval_q, 1'b0} + {2'b0, interval_q},
                                  profile_i);
    off_b4_q      <= offline_calc(rto_q, {interval_q, 2'b0}, profile_i);
    off_b3_susp_q <= offline_calc(rto_q, 12'd300, profile_i);
    off_b4_susp_q <= offline_calc(rto_q, 12'd400, profile_i);
  end

  assign timers_o.interval    = interval_q;
  assign timers_o.rto         = rto_q;
  assign timers_o.off_b3      = off_b3_q;
  assign timers_o.off_b4      = off_b4_q;
  assign timers_o.off_b3_susp = off_b3_susp_q;
  assign timers_o.off_b4_susp = off_b4_susp_q;

endmodule

`default_nettype wire

@@ hw/rtl/llm_state.sv @@
// Estimator and health state registers with their per-item update logic.
`default_nettype none

module llm_state (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [2:0]            cmd_i,
  input  wire logic [47:0]           now_i,
  input  wire logic [31:0]           rtt_i,
  input  wire logic                  fix_i,
  input  llm_pkg::timers_t           timers_i,
  output llm_pkg::state_t            state_o
);

  llm_pkg::state_t state_q, state_d;

  logic [31:0] rtt1;
  logic [31:0] err;
  logic [34:0] var_sum;
  logic [34:0] srtt_sum;
  logic [19:0] loss7;
  logic [19:0] loss_miss;
  logic [47:0] age;
  logic [7:0]  budget;

  always_comb begin
    rtt1      = (rtt_i == 32'd0) ? 32'd1 : rtt_i;
    err       = (rtt1 > state_q.srtt) ? rtt1 - state_q.srtt : state_q.srtt - rtt1;
    var_sum   = {2'b0, state_q.rttvar, 1'b0} + {3'b0, state_q.rttvar} + {3'b0, err};
    srtt_sum  = {state_q.srtt, 3'b0} - {3'b0, state_q.srtt} + {3'b0, rtt1};
    loss7     = {state_q.loss, 3'b0} - {3'b0, state_q.loss};
    loss_miss = loss7 + llm_pkg::LOSS_MISS_STEP;
    age       = (now_i >= state_q.last_ack) ? now_i - state_q.last_ack : 48'd0;
    budget    = llm_pkg::low_loss(state_q.loss) ? 8'd3 : 8'd4;

    state_d = state_q;
    // Finish the probe schedule of a success once its new interval is known
    if (fix_i) begin
      state_d.next_probe = llm_pkg::sat_add48(state_q.next_probe, timers_i.interval);
    end
    if (accept_i) begin
      case (cmd_i)
        llm_pkg::CMD_RESTART: begin
          state_d.health     = llm_pkg::HEALTH_UNKNOWN;
          state_d.srtt       = llm_pkg::SRTT_RESET;
          state_d.rttvar     = llm_pkg::RTTVAR_RESET;
          state_d.loss       = 17'd0;
          state_d.miss       = 8'd0;
          state_d.seeded     = 1'b0;
          state_d.last_ack   = now_i;
          state_d.next_probe = now_i;
        end
        llm_pkg::CMD_SUCCESS: begin
          if (!state_q.seeded) begin
            state_d.srtt   = rtt1;
            state_d.rttvar = {1'b0, rtt1[31:1]};
            state_d.seeded = 1'b1;
          end else begin
            state_d.rttvar = var_sum[33:2];
            state_d.srtt   = srtt_sum[34:3];
          end
          state_d.loss       = loss7[19:3];
          state_d.last_ack   = now_i;
          state_d.miss       = 8'd0;
          state_d.health     = llm_pkg::HEALTH_HEALTHY;
          // Hold the base time; the interval is added after the timers refresh
          state_d.next_probe = now_i;
        end
        llm_pkg::CMD_MISS: begin
          state_d.loss = loss_miss[19:3];
          if (state_q.miss != llm_pkg::MISS_MAX) begin
            state_d.miss = state_q.miss + 8'd1;
          end
          if (state_q.health != llm_pkg::HEALTH_OFFLINE) begin
            state_d.health = llm_pkg::HEALTH_SUSPECT;
          end
        end
        llm_pkg::CMD_TICK: begin
          if (age >= {37'b0, llm_pkg::cur_offline(state_q.health, state_q.loss, timers_i)}
              && state_q.miss >= budget) begin
            state_d.health = llm_pkg::HEALTH_OFFLINE;
          end else if (state_q.miss != 8'd0 || age >= {38'b0, timers_i.rto}) begin
            state_d.health = llm_pkg::HEALTH_SUSPECT;
          end else if (state_q.seeded) begin
            state_d.health = llm_pkg::HEALTH_HEALTHY;
          end
        end
        llm_pkg::CMD_PROBE_SENT: begin
          state_d.next_probe =
            llm_pkg::sat_add48(now_i, llm_pkg::cur_interval(state_q.health, timers_i));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.health     <= llm_pkg::HEALTH_UNKNOWN;
      state_q.srtt       <= llm_pkg::SRTT_RESET;
      state_q.rttvar     <= llm_pkg::RTTVAR_RESET;
      state_q.loss       <= 17'd0;
      state_q.miss       <= 8'd0;
      state_q.seeded     <= 1'b0;
      state_q.last_ack   <= 48'd0;
      state_q.next_probe <= 48'd0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

@@ hw/rtl/llm_result.sv @@
// Result register: forms the reported fields and holds them while stalled.
`default_nettype none

module llm_result (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic                  out_stall_i,
  input  llm_pkg::state_t            state_i,
  input  llm_pkg::timers_t           timers_i,
  input  wire logic [47:0]           now_i,
  output logic                       out_valid_o,
  output logic [1:0]                 health_o,
  output logic                       probe_due_o,
  output logic [9:0]                 probe_interval_ms_o,
  output logic [9:0]                 rto_ms_o,
  output logic [10:0]                offline_ms_o,
  output logic [19:0]                loss_ppm_o
);

  logic        valid_q;
  logic [1:0]  health_q;
  logic        probe_due_q;
  logic [9:0]  interval_q;
  logic [9:0]  rto_q;
  logic [10:0] offline_q;
  logic [19:0] ppm_q;
  logic [30:0] ppm_prod;

  assign ppm_prod = {14'b0, state_i.loss} * {17'b0, llm_pkg::PPM_NUM};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      health_q    <= state_i.health;
      probe_due_q <= now_i >= state_i.next_probe;
      interval_q  <= llm_pkg::cur_interval(state_i.health, timers_i);
      rto_q       <= timers_i.rto;
      offline_q   <= llm_pkg::cur_offline(state_i.health, state_i.loss, timers_i);
      ppm_q       <= ppm_prod[29:10];
    end
  end

  assign out_valid_o         = valid_q;
  assign health_o            = health_q;
  assign probe_due_o         = probe_due_q;
  assign probe_interval_ms_o = interval_q;
  assign rto_ms_o            = rto_q;
  assign offline_ms_o        = offline_q;
  assign loss_ppm_o          = ppm_q;

endmodule

`default_nettype wire

@@ hw/rtl/link_liveness_monitor.sv @@
// Top level of the link liveness monitor: handshake, refresh control and config.
// Result: an accepted item's result is loaded into the result register once no
//   timer refresh is pending, so a restart or a probe success waits for its refresh.
// Throughput: one item per cycle for miss, tick, probe sent and unused codes while
//   the result is not stalled; restart, probe success and a config write refresh
//   the two-stage timer pipeline, which holds off the next item until it settles.
// Reset: asynchronous, active low; state returns to its initial estimates and
//   no item is taken while the timers settle.
`default_nettype none

module link_liveness_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] rtt_us_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       health_o,
  output logic             probe_due_o,
  output logic [9:0]       probe_interval_ms_o,
  output logic [9:0]       rto_ms_o,
  output logic [10:0]      offline_ms_o,
  output logic [19:0]      loss_ppm_o
);

  logic             profile_q;
  logic [1:0]       stale_q, stale_d;
  logic             fix_q, fix_d;
  logic             pend_q, pend_d;
  logic [47:0]      pend_now_q;
  logic             in_acc;
  logic             pend_go;
  logic             refresh;

  llm_pkg::state_t  state;
  llm_pkg::timers_t timers;

  assign pend_go    = pend_q && (stale_q == 2'd0) && (!out_valid_o || !out_stall_i);
  assign in_stall_o = (stale_q != 2'd0) || (pend_q && !pend_go);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign refresh    = cfg_we_i || (in_acc && (cmd_i == llm_pkg::CMD_RESTART ||
                                             cmd_i == llm_pkg::CMD_SUCCESS));

  always_comb begin
    stale_d = stale_q;
    if (refresh) begin
      stale_d = 2'd2;
    end else if (stale_q != 2'd0) begin
      stale_d = stale_q - 2'd1;
    end

    fix_d = fix_q;
    if (in_acc && cmd_i == llm_pkg::CMD_SUCCESS) begin
      fix_d = 1'b1;
    end else if (stale_q == 2'd1) begin
      fix_d = 1'b0;
    end

    pend_d = pend_q;
    if (in_acc) begin
      pend_d = 1'b1;
    end else if (pend_go) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q <= 1'b0;
      stale_q   <= 2'd2;
      fix_q     <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        profile_q <= cfg_wdata_i;
      end
      stale_q <= stale_d;
      fix_q   <= fix_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_now_q <= now_ms_i;
    end
  end

  llm_timers u_timers (
    .clk_i     (clk_i),
    .profile_i (profile_q),
    .srtt_i    (state.srtt),
    .rttvar_i  (state.rttvar),
    .timers_o  (timers)
  );

  llm_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .cmd_i    (cmd_i),
    .now_i    (now_ms_i),
    .rtt_i    (rtt_us_i),
    .fix_i    (fix_q && (stale_q == 2'd1)),
    .timers_i (timers),
    .state_o  (state)
  );

  llm_result u_result (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .load_i              (pend_go),
    .out_stall_i         (out_stall_i),
    .state_i             (state),
    .timers_i            (timers),
    .now_i               (pend_now_q),
    .out_valid_o         (out_valid_o),
    .health_o            (health_o),
    .probe_due_o         (probe_due_o),
    .probe_interval_ms_o (probe_interval_ms_o),
    .rto_ms_o            (rto_ms_o),
    .offline_ms_o        (offline_ms_o),
    .loss_ppm_o          (loss_ppm_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/llm_checker.sv @@
// Port-level checker for the link liveness monitor and its bind.
`default_nettype none

module llm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  cmd_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  health_o,
  input wire logic [9:0]  probe_interval_ms_o,
  input wire logic [9:0]  rto_ms_o,
  input wire logic [10:0] offline_ms_o,
  input wire logic [19:0] loss_ppm_o
);

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(offline_ms_o) && $stable(health_o))
    else $error("result changed while stalled");

  // A success refreshes the timers, so the next cycle takes no item
  a_success_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == 3'd1 |=> in_stall_o)
    else $error("item taken during timer refresh");

  a_suspect_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && health_o == 2'd2 |-> probe_interval_ms_o == 10'd100)
    else $error("suspect interval is not the fast rate");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> probe_interval_ms_o >= 10'd100 && probe_interval_ms_o <= 10'd750 &&
                    rto_ms_o >= 10'd100 && rto_ms_o <= 10'd1000 &&
                    offline_ms_o >= 11'd600 && offline_ms_o <= 11'd1800 &&
                    offline_ms_o >= {1'b0, rto_ms_o} && loss_ppm_o <= 20'd1000000)
    else $error("reported timer out of range");

endmodule

bind link_liveness_monitor llm_checker u_llm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .cmd_i               (cmd_i),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .health_o            (health_o),
  .probe_interval_ms_o (probe_interval_ms_o),
  .rto_ms_o            (rto_ms_o),
  .offline_ms_o        (offline_ms_o),
  .loss_ppm_o          (loss_ppm_o)
);

`default_nettype wire
